// ===== rtl/iis_pkg.sv =====
`timescale 1ns / 1ps
package iis_pkg;

  // Number of cells in the sorting chain.
  localparam int unsigned CAPACITY = 16;

  // Width of one integer word.
  localparam int unsigned WIDTH = 32;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic signed [WIDTH-1:0] value;
    logic                    occ;
    logic                    gt;
  } link_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                    insert;
    logic                    shift;
    logic signed [WIDTH-1:0] value;
  } ctl_t;

endpackage

// ===== rtl/iis_if.sv =====
`timescale 1ns / 1ps
// Word channel carrying unsorted integers into the sorter.
interface iis_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iis_pkg::WIDTH-1:0]     value;
  logic                                 final_item;

  modport source(output valid, output value, output final_item, input ready);
  modport sink(input valid, input value, input final_item, output ready);
endinterface

// Word channel carrying the sorted run out of the sorter.
interface iis_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iis_pkg::WIDTH-1:0]     sorted_value;
  logic                                 run_end;
  logic                                 overflow;

  modport source(output valid, output sorted_value, output run_end, output overflow,
                 input ready);
  modport sink(input valid, input sorted_value, input run_end, input overflow,
               output ready);
endinterface

// ===== rtl/iis_cell.sv =====
`timescale 1ns / 1ps
module iis_cell (
  input  logic           clk,
  input  logic           rst,
  input  iis_pkg::ctl_t  ctl,
  input  iis_pkg::link_t left,
  input  iis_pkg::link_t right,
  output iis_pkg::link_t link
);

  logic signed [iis_pkg::WIDTH-1:0] value;
  logic signed [iis_pkg::WIDTH-1:0] value_next;
  logic                             occ;
  logic                             occ_next;
  logic                             gt;

  // The held word is strictly greater than the broadcast word, so it moves right.
  assign gt = occ && (value > ctl.value);

  // On insert, a cell that must make room takes its left neighbor's word when that
  // one also moves, otherwise the new word. On shift, the chain moves one place left.
  always_comb begin
    value_next = value;
    occ_next   = occ;
    if (ctl.shift) begin
      value_next = right.value;
      occ_next   = right.occ;
    end else if (ctl.insert && (gt || !occ) && left.occ) begin
      value_next = left.gt ? left.value : ctl.value;
      occ_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  assign link.value = value;
  assign link.occ   = occ;
  assign link.gt    = gt;

endmodule

// ===== rtl/integer_insertion_sorter.sv =====
`timescale 1ns / 1ps
// Latency: a word sits in its cell from the edge that takes it; the first sorted word
// is offered in the cycle after the word flagged final is taken.
// Throughput: one word per cycle while a set is collected; the drain moves one word
// per accepted output.
// No word is taken during the drain. The run is emitted straight from the first cell.
// Reset clears every occupancy bit and the drain and drop flags; no clearing pass.
module integer_insertion_sorter #(
  parameter int unsigned CAPACITY = iis_pkg::CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  iis_in_if.sink    in_ch,
  iis_out_if.source out_ch
);

  iis_pkg::link_t links [CAPACITY];
  iis_pkg::ctl_t  ctl;

  logic draining;
  logic dropped;
  logic in_acc;
  logic out_acc;
  logic full;
  logic last_word;

  assign full      = links[CAPACITY-1].occ;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_acc   = out_ch.valid && out_ch.ready;
  assign last_word = !links[1].occ;

  // Broadcast command: insert while collecting, shift left while draining.
  assign ctl.insert = in_acc && !full;
  assign ctl.shift  = out_acc;
  assign ctl.value  = in_ch.value;

  // Chain of cells; the ends see a fixed full neighbor on the left, empty on the right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    iis_pkg::link_t left;
    iis_pkg::link_t right;

    if (i == 0) begin : g_head
      assign left = '{value: '0, occ: 1'b1, gt: 1'b0};
    end else begin : g_mid_l
      assign left = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right = '{value: '0, occ: 1'b0, gt: 1'b0};
    end else begin : g_mid_r
      assign right = links[i+1];
    end

    iis_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .left (left),
      .right(right),
      .link (links[i])
    );
  end

  // Drain and drop flags for the current set.
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      if (in_acc && in_ch.final_item) begin
        draining <= 1'b1;
      end else if (out_acc && last_word) begin
        draining <= 1'b0;
      end
      if (in_acc && full) begin
        dropped <= 1'b1;
      end else if (out_acc && last_word) begin
        dropped <= 1'b0;
      end
    end
  end

  assign in_ch.ready         = !draining;
  assign out_ch.valid        = draining && links[0].occ;
  assign out_ch.sorted_value = links[0].value;
  assign out_ch.run_end      = last_word;
  assign out_ch.overflow     = dropped;

  // The two sides never run at once.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a run is pending");

  // A drain that is not at its last word keeps offering words.
  a_drain_cont: assert property (@(posedge clk) disable iff (rst)
    out_acc && !out_ch.run_end |=> out_ch.valid)
    else $error("run broke off before its last word");

  // The last word of a run hands control back to the input side.
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    out_acc && out_ch.run_end |=> in_ch.ready && !out_ch.overflow)
    else $error("run end did not empty the store");

  // A set closed by the final word always has at least one word to emit.
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_ch.final_item |=> out_ch.valid)
    else $error("closed set produced no run");

endmodule
